// ----- sv/quaternion_to_euler_angles_unit_assert.svh -----
// assertion macros used by the rtl
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_ASSERT_SVH

// checked only outside reset
`define Q2E_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// checked in every cycle, reset included
`define Q2E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/q2e_pkg.sv -----
`timescale 1ns / 1ps
package q2e_pkg;

  localparam int VEC_W = 36;
  localparam int ANG_W = 34;
  localparam int PRD_W = 51;
  localparam int SQRT_STEPS = 31;
  localparam int ROOT_W = 31;
  localparam int REM_W = 33;
  localparam int RAD_W = 62;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [PRD_W-1:0] prd_t;

  localparam logic signed [ANG_W-1:0] ATAN_TURN [32] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
    34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
    34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
    34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
    34'sd652, 34'sd326, 34'sd163, 34'sd81,
    34'sd41, 34'sd20, 34'sd10, 34'sd5,
    34'sd3, 34'sd1, 34'sd1, 34'sd0
  };

  localparam logic signed [ANG_W-1:0] HALF_TURN = 34'sd2147483648;

endpackage

// ----- sv/q2e_sqrt_cell.sv -----
`timescale 1ns / 1ps
module q2e_sqrt_cell (
  input  logic                             clk,
  input  logic                             en,
  input  logic [q2e_pkg::REM_W-1:0]        rem_in,
  input  logic [q2e_pkg::ROOT_W-1:0]       root_in,
  input  logic [q2e_pkg::RAD_W-1:0]        rad_in,
  output logic [q2e_pkg::REM_W-1:0]        rem_out,
  output logic [q2e_pkg::ROOT_W-1:0]       root_out,
  output logic [q2e_pkg::RAD_W-1:0]        rad_out
);
  import q2e_pkg::*;

  logic [REM_W+1:0]  rem_t;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              take;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [RAD_W-1:0]  rad_r;

  always_comb begin
    rem_t    = {rem_in, rad_in[RAD_W-1 -: 2]};
    trial    = {2'b00, root_in, 2'b01};
    diff     = rem_t - trial;
    take     = (rem_t >= trial);
    rem_nxt  = take ? diff[REM_W-1:0] : rem_t[REM_W-1:0];
    root_nxt = {root_in[ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= {rad_in[RAD_W-3:0], 2'b00};
    end
  end

  assign rem_out  = rem_r;
  assign root_out = root_r;
  assign rad_out  = rad_r;
endmodule

// ----- sv/q2e_cordic_cell.sv -----
`timescale 1ns / 1ps
module q2e_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          en,
  input  q2e_pkg::vec_t x_in,
  input  q2e_pkg::vec_t y_in,
  input  q2e_pkg::ang_t z_in,
  input  logic          zf_in,
  output q2e_pkg::vec_t x_out,
  output q2e_pkg::vec_t y_out,
  output q2e_pkg::ang_t z_out,
  output logic          zf_out
);
  import q2e_pkg::*;

  vec_t dx, dy, x_nxt, y_nxt, x_r, y_r;
  ang_t z_nxt, z_r;
  logic zf_r;

  always_comb begin
    dx = x_in >>> STAGE;
    dy = y_in >>> STAGE;
    if (!y_in[VEC_W-1]) begin
      x_nxt = x_in + dy;
      y_nxt = y_in - dx;
      z_nxt = z_in + ATAN_TURN[STAGE];
    end else begin
      x_nxt = x_in - dy;
      y_nxt = y_in + dx;
      z_nxt = z_in - ATAN_TURN[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
      zf_r <= zf_in;
    end
  end

  assign x_out  = x_r;
  assign y_out  = y_r;
  assign z_out  = z_r;
  assign zf_out = zf_r;
endmodule

// ----- sv/q2e_cordic.sv -----
`timescale 1ns / 1ps
module q2e_cordic #(
  parameter int STAGES = 16
) (
  input  logic          clk,
  input  logic          en,
  input  q2e_pkg::vec_t x_in,
  input  q2e_pkg::vec_t y_in,
  output q2e_pkg::prd_t ang_out
);
  import q2e_pkg::*;

  vec_t xs [STAGES+1];
  vec_t ys [STAGES+1];
  ang_t zs [STAGES+1];
  logic zfs [STAGES+1];

  vec_t x0_nxt, y0_nxt, x0_r, y0_r;
  ang_t z0_nxt, z0_r;
  logic zf0_r;
  prd_t prd_nxt;
  prd_t prd_r;

  // fold left half plane into the right
  always_comb begin
    if (x_in[VEC_W-1]) begin
      x0_nxt = -x_in;
      y0_nxt = -y_in;
      z0_nxt = y_in[VEC_W-1] ? -HALF_TURN : HALF_TURN;
    end else begin
      x0_nxt = x_in;
      y0_nxt = y_in;
      z0_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r  <= x0_nxt;
      y0_r  <= y0_nxt;
      z0_r  <= z0_nxt;
      zf0_r <= (x_in == '0) && (y_in == '0);
    end
  end

  assign xs[0]  = x0_r;
  assign ys[0]  = y0_r;
  assign zs[0]  = z0_r;
  assign zfs[0] = zf0_r;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    q2e_cordic_cell #(.STAGE(i)) u_cell (
      .clk    (clk),
      .en     (en),
      .x_in   (xs[i]),
      .y_in   (ys[i]),
      .z_in   (zs[i]),
      .zf_in  (zfs[i]),
      .x_out  (xs[i+1]),
      .y_out  (ys[i+1]),
      .z_out  (zs[i+1]),
      .zf_out (zfs[i+1])
    );
  end

  // scale turn fraction to hundredths of a degree
  always_comb begin
    prd_nxt = prd_t'(zs[STAGES]) * prd_t'(18'sd36000);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prd_r <= zfs[STAGES] ? '0 : prd_nxt;
    end
  end

  assign ang_out = prd_r;
endmodule

// ----- sv/quaternion_to_euler_angles_unit.sv -----
`timescale 1ns / 1ps
// throughput: one word per cycle while the output is accepted; set by the pipelined square root and cordic chains
// the whole pipeline holds while an output word waits unaccepted
// reset: synchronous active-low rst_n clears all valid flags and sets declination to 1380
module quaternion_to_euler_angles_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // roll_angle, pitch_angle, yaw_angle, pad
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data // declination
);
  import q2e_pkg::*;
  `include "quaternion_to_euler_angles_unit_assert.svh"

  localparam int LAT = 37 + CORDIC_STAGES;

  typedef struct packed {
    vec_t               ry;
    vec_t               rx;
    vec_t               yn;
    vec_t               yx;
    logic signed [31:0] s;
  } ops_t;

  logic               en;
  logic [LAT-1:0]     vld_r, vld_nxt;
  logic signed [15:0] decl_r;

  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] ww_r, xx_r, yy_r, zz_r, wx_r, yz_r, xy_r, wz_r, xz_r, wy_r;

  ops_t               ops_nxt, ops_r;
  logic signed [33:0] s_full;

  logic [30:0]        s_abs;
  logic [30:0]        fac_a;
  logic [31:0]        fac_b;
  logic [RAD_W-1:0]   rad_r;
  ops_t               dly_r [SQRT_STEPS+1];

  logic [REM_W-1:0]   rems  [SQRT_STEPS+1];
  logic [ROOT_W-1:0]  roots [SQRT_STEPS+1];
  logic [RAD_W-1:0]   rads  [SQRT_STEPS+1];

  prd_t               roll_p, pitch_p, yaw_p;
  logic signed [PRD_W:0] roll_sum, pitch_sum, yaw_sum;
  logic signed [18:0] roll_q, pitch_q, yaw_q;
  logic signed [19:0] yaw_d, yaw_w;
  logic signed [15:0] roll_nxt;
  logic signed [14:0] pitch_nxt;
  logic [15:0]        yaw_nxt;
  logic signed [15:0] roll_r;
  logic signed [14:0] pitch_r;
  logic [15:0]        yaw_r;

  assign en         = !vld_r[LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {1'b0, yaw_r, pitch_r, roll_r};
  assign vld_nxt    = {vld_r[LAT-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      decl_r <= 16'sd1380;
    end else begin
      if (en) vld_r <= vld_nxt;
      if (cfg_wr_en) decl_r <= cfg_wr_data;
    end
  end

  // component products
  assign qw = in_tdata[15:0];
  assign qx = in_tdata[31:16];
  assign qy = in_tdata[47:32];
  assign qz = in_tdata[63:48];

  always_ff @(posedge clk) begin
    if (en) begin
      ww_r <= qw * qw;
      xx_r <= qx * qx;
      yy_r <= qy * qy;
      zz_r <= qz * qz;
      wx_r <= qw * qx;
      yz_r <= qy * qz;
      xy_r <= qx * qy;
      wz_r <= qw * qz;
      xz_r <= qx * qz;
      wy_r <= qw * qy;
    end
  end

  // atan2 operands and clamped arcsine argument
  always_comb begin
    ops_nxt.ry = (VEC_W'(wx_r) + VEC_W'(yz_r)) <<< 1;
    ops_nxt.rx = VEC_W'(ww_r) - VEC_W'(xx_r) - VEC_W'(yy_r) + VEC_W'(zz_r);
    ops_nxt.yn = (VEC_W'(xy_r) + VEC_W'(wz_r)) <<< 1;
    ops_nxt.yx = VEC_W'(ww_r) + VEC_W'(xx_r) - VEC_W'(yy_r) - VEC_W'(zz_r);
    s_full     = (34'(xz_r) - 34'(wy_r)) <<< 1;
    if (s_full > 34'sd1073741824)
      ops_nxt.s = 32'sd1073741824;
    else if (s_full < -34'sd1073741824)
      ops_nxt.s = -32'sd1073741824;
    else
      ops_nxt.s = s_full[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) ops_r <= ops_nxt;
  end

  // radicand (1 - s)(1 + s)
  always_comb begin
    s_abs = ops_r.s[31] ? 31'(-ops_r.s) : ops_r.s[30:0];
    fac_a = 31'd1073741824 - s_abs;
    fac_b = 32'd1073741824 + {1'b0, s_abs};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r    <= RAD_W'(fac_a) * RAD_W'(fac_b);
      dly_r[0] <= ops_r;
      for (int k = 1; k <= SQRT_STEPS; k++) dly_r[k] <= dly_r[k-1];
    end
  end

  assign rems[0]  = '0;
  assign roots[0] = '0;
  assign rads[0]  = rad_r;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    q2e_sqrt_cell u_sqrt (
      .clk      (clk),
      .en       (en),
      .rem_in   (rems[j]),
      .root_in  (roots[j]),
      .rad_in   (rads[j]),
      .rem_out  (rems[j+1]),
      .root_out (roots[j+1]),
      .rad_out  (rads[j+1])
    );
  end

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk     (clk),
    .en      (en),
    .x_in    (dly_r[SQRT_STEPS].rx),
    .y_in    (dly_r[SQRT_STEPS].ry),
    .ang_out (roll_p)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk     (clk),
    .en      (en),
    .x_in    (VEC_W'({1'b0, roots[SQRT_STEPS]})),
    .y_in    (VEC_W'(dly_r[SQRT_STEPS].s)),
    .ang_out (pitch_p)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk     (clk),
    .en      (en),
    .x_in    (dly_r[SQRT_STEPS].yx),
    .y_in    (dly_r[SQRT_STEPS].yn),
    .ang_out (yaw_p)
  );

  // round half up, clamp, add declination and wrap
  always_comb begin
    roll_sum  = (PRD_W+1)'(roll_p) + (PRD_W+1)'(64'sd2147483648);
    pitch_sum = (PRD_W+1)'(pitch_p) + (PRD_W+1)'(64'sd2147483648);
    yaw_sum   = (PRD_W+1)'(yaw_p) + (PRD_W+1)'(64'sd2147483648);
    roll_q    = roll_sum[50:32];
    pitch_q   = -pitch_sum[50:32];
    yaw_q     = yaw_sum[50:32];

    if (roll_q > 19'sd18000) roll_nxt = 16'sd18000;
    else if (roll_q < -19'sd18000) roll_nxt = -16'sd18000;
    else roll_nxt = roll_q[15:0];

    if (pitch_q > 19'sd9000) pitch_nxt = 15'sd9000;
    else if (pitch_q < -19'sd9000) pitch_nxt = -15'sd9000;
    else pitch_nxt = pitch_q[14:0];

    yaw_d = 20'(yaw_q) + 20'(decl_r);
    yaw_w = yaw_d[19] ? yaw_d + 20'sd36000 : yaw_d;
    if (yaw_w < 20'sd0) yaw_nxt = 16'd0;
    else if (yaw_w > 20'sd36000) yaw_nxt = 16'd36000;
    else yaw_nxt = yaw_w[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= roll_nxt;
      pitch_r <= pitch_nxt;
      yaw_r   <= yaw_nxt;
    end
  end

  `Q2E_ASSERT_NEXT(a_reset_empty, !rst_n, !out_tvalid, "output valid right after reset")
  `Q2E_ASSERT(a_yaw_range, out_tvalid, out_tdata[46:31] <= 16'd36000, "yaw out of range")
  `Q2E_ASSERT(a_roll_range, out_tvalid,
    $signed(out_tdata[15:0]) <= 16'sd18000 && $signed(out_tdata[15:0]) >= -16'sd18000,
    "roll out of range")
  `Q2E_ASSERT(a_pitch_range, out_tvalid,
    $signed(out_tdata[30:16]) <= 15'sd9000 && $signed(out_tdata[30:16]) >= -15'sd9000,
    "pitch out of range")
endmodule

// ----- tb/tb_quaternion_to_euler_angles_unit.sv -----
`timescale 1ns / 1ps
module tb_quaternion_to_euler_angles_unit;

  localparam int STAGES = 16;
  localparam int LATENCY = 37 + STAGES;
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint HALF_TURN_L = 64'sd1 << 31;

  typedef struct packed {
    logic signed [15:0] qz;
    logic signed [15:0] qy;
    logic signed [15:0] qx;
    logic signed [15:0] qw;
  } quat_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic [15:0] yaw;
  } euler_t;

  typedef struct {
    bit is_cfg;
    logic [15:0] cfg_value;
    quat_t quat;
  } stim_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [47:0] out_tdata;
  logic cfg_wr_en = 0;
  logic [15:0] cfg_wr_data = '0;

  quaternion_to_euler_angles_unit #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  stim_t pending_words[$];
  euler_t expected_angles[$];
  longint model_declination = 1380;
  int errors = 0;
  bit stim_done = 0;
  int long_hold = 0;
  bit in_fire = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint int_sqrt(longint n);
    longint root;
    longint bitv;
    root = 0;
    bitv = 64'sd1 << 62;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >>> 1) + bitv;
      end else begin
        root = root >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return root;
  endfunction

  function automatic longint vector_angle(longint ay, longint ax);
    longint acc;
    longint dx;
    longint dy;
    acc = 0;
    if (ax == 0 && ay == 0) return 0;
    if (ax < 0) begin
      acc = (ay >= 0) ? HALF_TURN_L : -HALF_TURN_L;
      ax = -ax;
      ay = -ay;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = floor_shr(ay, i);
      dy = floor_shr(ax, i);
      if (ay >= 0) begin
        ax += dx; ay -= dy; acc += longint'(q2e_pkg::ATAN_TURN[i]);
      end else begin
        ax -= dx; ay += dy; acc -= longint'(q2e_pkg::ATAN_TURN[i]);
      end
    end
    return acc;
  endfunction

  function automatic longint turn_to_centideg(longint a);
    longint p;
    p = a * 36000 + (64'sd36000 << 32) + HALF_TURN_L;
    return (p >>> 32) - 36000;
  endfunction

  function automatic euler_t predict_angles(quat_t q);
    longint w, x, y, z, s, c, r, p, yw;
    euler_t e;
    w = q.qw; x = q.qx; y = q.qy; z = q.qz;
    s = clampl(2 * (x * z - w * y), -ONE_Q30, ONE_Q30);
    c = int_sqrt(ONE_Q30 * ONE_Q30 - s * s);
    r = clampl(turn_to_centideg(vector_angle(2 * (w * x + y * z),
        w * w - x * x - y * y + z * z)), -18000, 18000);
    p = clampl(-turn_to_centideg(vector_angle(s, c)), -9000, 9000);
    yw = turn_to_centideg(vector_angle(2 * (x * y + w * z),
         w * w + x * x - y * y - z * z)) + model_declination;
    if (yw < 0) yw += 36000;
    yw = clampl(yw, 0, 36000);
    e.roll = r[15:0];
    e.pitch = p[14:0];
    e.yaw = yw[15:0];
    return e;
  endfunction

  function automatic quat_t unit_like_quat();
    quat_t q;
    real a, b, cc, d, n;
    a = real'($urandom_range(0, 65534)) - 32767.0;
    b = real'($urandom_range(0, 65534)) - 32767.0;
    cc = real'($urandom_range(0, 65534)) - 32767.0;
    d = real'($urandom_range(0, 65534)) - 32767.0;
    n = $sqrt(a * a + b * b + cc * cc + d * d);
    if (n < 1.0) n = 1.0;
    q.qw = 16'($rtoi(a / n * 32767.0));
    q.qx = 16'($rtoi(b / n * 32767.0));
    q.qy = 16'($rtoi(cc / n * 32767.0));
    q.qz = 16'($rtoi(d / n * 32767.0));
    return q;
  endfunction

  task automatic push_quat(quat_t q);
    stim_t s;
    s.is_cfg = 0;
    s.cfg_value = '0;
    s.quat = q;
    pending_words.push_back(s);
  endtask

  task automatic push_cfg(logic [15:0] v);
    stim_t s;
    s.is_cfg = 1;
    s.cfg_value = v;
    s.quat = '0;
    pending_words.push_back(s);
  endtask

  // driver: config writes only once the pipeline has drained
  always @(negedge clk) begin
    static int gap = 0;
    bit wr;
    wr = 0;
    if (rst_n) begin
      if (in_tvalid && !in_fire) begin
      end else if (gap > 0) begin
        in_tvalid <= 0;
        gap--;
      end else if (pending_words.size() > 0 && pending_words[0].is_cfg) begin
        in_tvalid <= 0;
        if (expected_angles.size() == 0 && !(in_tvalid)) begin
          wr = 1;
          cfg_wr_data <= pending_words[0].cfg_value;
          model_declination = longint'($signed(pending_words[0].cfg_value));
          void'(pending_words.pop_front());
          gap = LATENCY;
        end
      end else if (pending_words.size() > 0) begin
        in_tvalid <= 1;
        in_tdata <= pending_words[0].quat;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 4) < 2) gap = 0;
        void'(pending_words.pop_front());
      end else begin
        in_tvalid <= 0;
      end
    end
    cfg_wr_en <= wr;
  end

  // the prediction is made at acceptance with the declination in force
  always @(posedge clk) begin
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire)
      expected_angles.push_back(predict_angles(quat_t'(in_tdata)));
  end

  always @(posedge clk) begin
    euler_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_angles.size() == 0) begin
        $error("unexpected output word %h", out_tdata);
        errors++;
      end else begin
        e = expected_angles.pop_front();
        if (out_tdata[15:0] !== e.roll) begin
          $error("roll_angle expected %0d actual %0d", e.roll, $signed(out_tdata[15:0]));
          errors++;
        end
        if (out_tdata[30:16] !== e.pitch) begin
          $error("pitch_angle expected %0d actual %0d", e.pitch,
                 $signed(out_tdata[30:16]));
          errors++;
        end
        if (out_tdata[46:31] !== e.yaw) begin
          $error("yaw_angle expected %0d actual %0d", e.yaw, out_tdata[46:31]);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off
  always @(negedge clk) begin
    static int stall = 0;
    if (long_hold > 0) begin
      out_tready <= 0;
      long_hold--;
    end else if (stall > 0) begin
      out_tready <= 0;
      stall--;
    end else begin
      out_tready <= 1;
      if (out_tvalid) stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 4) < 2) stall = 0;
    end
  end

  initial begin
    quat_t q;
    static logic [15:0] decl_set[5] = '{16'sd0, -16'sd18000, 16'sd18000, -16'sd32768,
                                        16'sd32767};
    repeat (3) @(posedge clk);
    rst_n <= 1;
    // directed: extremes and special cases at reset declination
    push_quat('0);
    push_quat({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    push_quat({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    push_quat({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
    push_quat({16'sh0000, 16'sh0000, 16'sh0000, 16'sh7fff});
    push_quat({16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000});
    push_quat({16'sh0000, 16'sh0000, 16'sh7fff, 16'sh0000});
    push_quat({16'sh0000, 16'sh7fff, 16'sh0000, 16'sh0000});
    push_quat({16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000});
    push_quat({16'sh5a82, 16'sh0000, 16'sh5a82, 16'sh0000});
    push_quat({16'sh0000, 16'shA57E, 16'sh0000, 16'sh5a82});
    push_quat({16'sh4000, 16'sh4000, 16'shC000, 16'sh4000});
    push_quat({16'sh0000, 16'sh0001, 16'sh0000, 16'shffff});
    push_quat({16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000});
    push_quat({16'shffff, 16'sh0000, 16'sh0001, 16'sh0000});
    for (int k = 0; k < 5; k++) begin
      push_cfg(decl_set[k]);
      for (int i = 0; i < 30; i++) push_quat(unit_like_quat());
    end
    for (int ph = 0; ph < 4; ph++) begin
      push_cfg(16'($urandom_range(0, 36000) - 18000));
      for (int i = 0; i < 140; i++) begin
        if ($urandom_range(0, 3) == 0) q = quat_t'({$urandom, $urandom});
        else q = unit_like_quat();
        push_quat(q);
      end
    end
    push_cfg(16'sd1380);
    for (int i = 0; i < 10; i++) push_quat(unit_like_quat());
    wait (pending_words.size() <= 400);
    long_hold = 200;
    wait (pending_words.size() == 0 && !in_tvalid);
    wait (expected_angles.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_angles.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/q2e_pkg.sv
sv/q2e_sqrt_cell.sv
sv/q2e_cordic_cell.sv
sv/q2e_cordic.sv
sv/quaternion_to_euler_angles_unit.sv
tb/tb_quaternion_to_euler_angles_unit.sv
